[rtl/core/sars_pkg.sv]
// Package for the sorted array range search block.
// Shared widths, defaults and request opcodes; no dependencies.
package sars_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = 11;
	localparam int OP_W      = 2;

	// Request opcodes; code 3 is unused and ignored.
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

endpackage

[rtl/core/sars_req_if.sv]
// Request channel of the range search block: opcode and value.
// Depends on sars_pkg for field widths.
interface sars_req_if
	import sars_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

[rtl/core/sars_rsp_if.sv]
// Result channel of the range search block: indices, match count, found flag.
// Depends on sars_pkg for field widths.
interface sars_rsp_if
	import sars_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic signed [IDX_W-1:0] first_index;
	logic signed [IDX_W-1:0] last_index;
	logic [IDX_W-1:0]        match_count;
	logic                    found;

	modport source (output valid, output first_index, output last_index,
		output match_count, output found, input ready);
	modport sink   (input valid, input first_index, input last_index,
		input match_count, input found, output ready);
endinterface

[rtl/core/sorted_array_range_search_top.sv]
// Sorted array range search: clear and append complete when accepted. A query
// runs two binary searches, one memory probe per cycle, through a synchronous
// store with a registered read port; the result waits in the finish state until
// the output register is free, and the next request is taken once it is loaded.
// One query is in flight at a time. Reset clears the entry count and control;
// the store contents are left as they are and no clearing pass is run.
// Depends on sars_pkg, sars_req_if and sars_rsp_if.
module sorted_array_range_search_top
	import sars_pkg::*;
	#(
	parameter int DEPTH = DEPTH_DEF
	) (
	input  logic       clk,
	input  logic       arst_n,
	sars_req_if.sink   req,
	sars_rsp_if.source rsp
	);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SRCH = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// Midpoint of the window [a, b), with a < b.
	function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b} - (CW+1)'(1);
		return s[AW:1];
	endfunction

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CW-1:0]           lo_q, hi_q;
	logic [AW-1:0]           mid_q;
	logic                    pass_q;
	logic                    hit_v_q, first_v_q;
	logic [AW-1:0]           hit_q, first_q;
	logic signed [VAL_W-1:0] rdata_q;
	logic signed [VAL_W-1:0] mem [DEPTH];

	logic                    res_v_q;
	logic signed [IDX_W-1:0] first_idx_q, last_idx_q;
	logic [IDX_W-1:0]        cnt_q;
	logic                    found_q;

	logic          req_acc, out_free, wr_en, rd_en;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] mid_ext, mid_inc, lo_n, hi_n;
	logic          eq, more;
	logic [CW-1:0] cnt_full;
	logic [AW+IDX_W-1:0] first_wide, last_wide;
	logic [CW+IDX_W-1:0] cnt_wide;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !res_v_q || rsp.ready;
	assign wr_en     = req_acc && (req.op == OP_APPEND) && (count_q < CW'(DEPTH));

	// Probe step: narrow the window by the entry read at mid_q.
	always_comb begin
		mid_ext = CW'(mid_q);
		mid_inc = mid_ext + CW'(1);
		eq      = (rdata_q == key_q);
		lo_n    = lo_q;
		hi_n    = hi_q;
		if (eq) begin
			if (pass_q) lo_n = mid_inc;
			else hi_n = mid_ext;
		end else if (rdata_q < key_q) begin
			lo_n = mid_inc;
		end else begin
			hi_n = mid_ext;
		end
		more = (lo_n < hi_n);
	end

	// Read port address: next probe, restart of the second search, or first probe.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid_of(lo_n, hi_n);
		case (state_q)
			ST_IDLE: begin
				rd_en   = req_acc && (req.op == OP_QUERY) && (count_q != '0);
				rd_addr = mid_of('0, count_q);
			end
			ST_SRCH: begin
				if (more) begin
					rd_en   = 1'b1;
					rd_addr = mid_of(lo_n, hi_n);
				end else if (!pass_q) begin
					rd_en   = 1'b1;
					rd_addr = mid_of('0, count_q);
				end
			end
			default: ;
		endcase
	end

	// Element store.
	always_ff @(posedge clk) begin
		if (wr_en) mem[count_q[AW-1:0]] <= req.value;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// Sequencer and search registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pass_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						case (req.op)
							OP_CLEAR:  count_q <= '0;
							OP_APPEND: if (wr_en) count_q <= count_q + CW'(1);
							OP_QUERY: begin
								pass_q  <= 1'b0;
								state_q <= (count_q != '0) ? ST_SRCH : ST_FIN;
							end
							default: ;
						endcase
					end
				end
				ST_SRCH: begin
					if (!more) begin
						if (!pass_q) pass_q <= 1'b1;
						else state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					key_q     <= req.value;
					lo_q      <= '0;
					hi_q      <= count_q;
					mid_q     <= mid_of('0, count_q);
					hit_v_q   <= 1'b0;
					first_v_q <= 1'b0;
				end
			end
			ST_SRCH: begin
				// last probe of the first search hands its hit to first_q instead
				if (eq && (more || pass_q)) begin
					hit_v_q <= 1'b1;
					hit_q   <= mid_q;
				end
				if (more) begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_of(lo_n, hi_n);
				end else if (!pass_q) begin
					first_v_q <= hit_v_q || eq;
					first_q   <= eq ? mid_q : hit_q;
					hit_v_q   <= 1'b0;
					lo_q      <= '0;
					hi_q      <= count_q;
					mid_q     <= mid_of('0, count_q);
				end
			end
			default: ;
		endcase
	end

	// Result formatting: indices and count truncated to the field width.
	always_comb begin
		cnt_full = '0;
		if (first_v_q && hit_v_q && (hit_q >= first_q))
			cnt_full = CW'(hit_q) - CW'(first_q) + CW'(1);
		first_wide = {{IDX_W{1'b0}}, first_q};
		last_wide  = {{IDX_W{1'b0}}, hit_q};
		cnt_wide   = {{IDX_W{1'b0}}, cnt_full};
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			res_v_q <= 1'b1;
		end else if (rsp.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			first_idx_q <= first_v_q ? first_wide[IDX_W-1:0] : '1;
			last_idx_q  <= hit_v_q ? last_wide[IDX_W-1:0] : '1;
			cnt_q       <= cnt_wide[IDX_W-1:0];
			found_q     <= (cnt_full != '0);
		end
	end

	assign rsp.valid       = res_v_q;
	assign rsp.first_index = first_idx_q;
	assign rsp.last_index  = last_idx_q;
	assign rsp.match_count = cnt_q;
	assign rsp.found       = found_q;

	// Checks.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q < hi_q) && (hi_q <= count_q))
		else $error("search window empty or beyond loaded entries");

	a_mid_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (CW'(mid_q) >= lo_q) && (CW'(mid_q) < hi_q))
		else $error("probe address outside window");

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !wr_en)
		else $error("store written during a query");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && out_free |=> res_v_q && (state_q == ST_IDLE))
		else $error("query result not registered");

endmodule

[tb/tb_sorted_array_range_search_top.sv]
// Testbench for sorted_array_range_search_top: directed, stalled, random and full-store runs.
// Results are checked against an in-bench predictor of the two binary searches.
// Depends on sars_pkg, sars_req_if, sars_rsp_if and the top level.
`timescale 1ns / 100ps

module tb_sorted_array_range_search_top;
	import sars_pkg::*;

	localparam int          DEPTH           = DEPTH_DEF;
	localparam int          CLK_HALF        = 5;
	localparam int          RESET_CYCLES    = 9;
	localparam int          QUERY_LATENCY   = 24;
	localparam int          TAIL_CYCLES     = 3 * QUERY_LATENCY;
	localparam int          RSP_HOLD_CYCLES = 400;
	localparam int          WATCHDOG_LIMIT  = 3000;
	localparam int          RANDOM_ITEMS    = 750;
	localparam int          MAX_PRINTS      = 40;
	localparam int          DIR_ROWS        = 25;

	// Opcode that the block ignores
	localparam logic [OP_W-1:0]         OP_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};

	typedef struct packed {
		logic signed [IDX_W-1:0] first_index;
		logic signed [IDX_W-1:0] last_index;
		logic [IDX_W-1:0]        match_count;
		logic                    found;
	} range_result_t;

	localparam range_result_t MISS   = '{-11'sd1, -11'sd1, 11'd0, 1'b0};
	localparam range_result_t NO_PIN = '0;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic signed [VAL_W-1:0] value;
		bit                      pinned;
		range_result_t           res;
	} dir_row_t;

	// Directed requests; pinned rows carry a hand-written answer
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{OP_QUERY,  32'sd0,   1'b1, MISS},      // empty after reset
		'{OP_QUERY,  VAL_MIN,  1'b1, MISS},
		'{OP_UNUSED, -32'sd1,  1'b0, NO_PIN},
		'{OP_QUERY,  32'sd0,   1'b1, MISS},      // unused op appended nothing
		'{OP_APPEND, VAL_MIN,  1'b0, NO_PIN},
		'{OP_APPEND, -32'sd5,  1'b0, NO_PIN},
		'{OP_APPEND, -32'sd5,  1'b0, NO_PIN},
		'{OP_APPEND, -32'sd5,  1'b0, NO_PIN},
		'{OP_APPEND, 32'sd0,   1'b0, NO_PIN},
		'{OP_APPEND, 32'sd7,   1'b0, NO_PIN},
		'{OP_APPEND, VAL_MAX,  1'b0, NO_PIN},
		'{OP_QUERY,  VAL_MIN,  1'b1, '{11'sd0, 11'sd0, 11'd1, 1'b1}},
		'{OP_QUERY,  VAL_MAX,  1'b1, '{11'sd6, 11'sd6, 11'd1, 1'b1}},
		'{OP_QUERY,  -32'sd5,  1'b0, NO_PIN},
		'{OP_QUERY,  32'sd3,   1'b1, MISS},
		'{OP_QUERY,  VAL_MAX - 32'sd1, 1'b0, NO_PIN},
		'{OP_CLEAR,  32'sd0,   1'b0, NO_PIN},
		'{OP_QUERY,  -32'sd5,  1'b1, MISS},      // cleared store
		'{OP_APPEND, 32'sd5,   1'b0, NO_PIN},    // out of order from here
		'{OP_APPEND, 32'sd1,   1'b0, NO_PIN},
		'{OP_APPEND, 32'sd9,   1'b0, NO_PIN},
		'{OP_APPEND, 32'sd1,   1'b0, NO_PIN},
		'{OP_QUERY,  32'sd1,   1'b0, NO_PIN},
		'{OP_QUERY,  32'sd9,   1'b0, NO_PIN},
		'{OP_CLEAR,  -32'sd1,  1'b0, NO_PIN}
	};

	logic clk = 1'b0;
	logic arst_n;

	sars_req_if req_ch ();
	sars_rsp_if rsp_ch ();

	sorted_array_range_search_top #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #CLK_HALF clk = ~clk;

	// Predictor state: mirror of the loaded entries
	logic signed [VAL_W-1:0] sorted_mem [DEPTH];
	int unsigned             loaded;

	range_result_t           pending_results [$];
	logic signed [VAL_W-1:0] key_pool [$];
	int                      err_cnt;
	int                      idle_cycles;
	int                      sent_cnt;
	bit                      no_idle;
	bit                      rsp_hold;

	// Midpoint-halving search; a hit narrows left for the first, right for the last
	function automatic int bisect(input logic signed [VAL_W-1:0] key, input bit want_last);
		int lo;
		int hi;
		int mid;
		int hit;
		lo  = 0;
		hi  = int'(loaded) - 1;
		hit = -1;
		while (lo <= hi) begin
			mid = (lo + hi) >>> 1;
			if (sorted_mem[mid] == key) begin
				hit = mid;
				if (want_last)
					lo = mid + 1;
				else
					hi = mid - 1;
			end else if (sorted_mem[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return hit;
	endfunction

	// Apply one request to the mirror and work out its result, if any
	function automatic void predict_request(input logic [OP_W-1:0] op,
		input logic signed [VAL_W-1:0] val, output bit has_res, output range_result_t res);
		int          lo_hit;
		int          hi_hit;
		int unsigned span;
		has_res = 1'b0;
		res     = '0;
		case (op)
			OP_CLEAR: begin
				loaded = 0;
			end
			OP_APPEND: begin
				if (loaded < DEPTH) begin
					sorted_mem[loaded] = val;
					loaded++;
				end
			end
			OP_QUERY: begin
				lo_hit = bisect(val, 1'b0);
				hi_hit = bisect(val, 1'b1);
				span   = (lo_hit >= 0 && hi_hit >= lo_hit) ? hi_hit - lo_hit + 1 : 0;
				res.first_index = lo_hit[IDX_W-1:0];
				res.last_index  = hi_hit[IDX_W-1:0];
				res.match_count = span[IDX_W-1:0];
				res.found       = (span != 0);
				has_res         = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request, wait for the handshake, then predict it
	task automatic send_req(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
		input bit pinned = 1'b0, input range_result_t pin_res = NO_PIN);
		int unsigned   gap;
		bit            has_res;
		range_result_t res;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (op != OP_UNUSED && !(op == OP_APPEND && loaded == DEPTH))
			sent_cnt++;
		predict_request(op, val, has_res, res);
		if (has_res)
			pending_results.push_back(pinned ? pin_res : res);
	endtask

	// Sender pause until every outstanding query has answered
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Nondecreasing appends from a random start, step up to spread
	task automatic load_sorted(input int n, input longint spread);
		longint v;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			v = VAL_MIN;
		else if (r < 20)
			v = longint'(VAL_MAX) - $urandom_range(0, 20);
		else
			v = longint'($signed($urandom));
		for (int i = 0; i < n; i++) begin
			send_req(OP_APPEND, v[VAL_W-1:0]);
			key_pool.push_back(v[VAL_W-1:0]);
			v = v + longint'($urandom_range(0, int'(spread)));
			if (v > longint'(VAL_MAX))
				v = VAL_MAX;
		end
	endtask

	function automatic longint pick_spread();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 50)
			return 2;
		if (r < 80)
			return 1000;
		return 64'd1 << 27;
	endfunction

	// Keys: mostly stored values, some neighbors, extremes and noise
	task automatic query_some(input int k);
		logic signed [VAL_W-1:0] key;
		int unsigned             r;
		for (int i = 0; i < k; i++) begin
			r = $urandom_range(0, 99);
			if (key_pool.size() != 0 && r < 50)
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else if (key_pool.size() != 0 && r < 70)
				key = key_pool[$urandom_range(0, key_pool.size() - 1)]
					+ (($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1);
			else if (r < 80)
				key = ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
			else
				key = $urandom;
			send_req(OP_QUERY, key);
		end
	endtask

	task automatic report_field(input string name, input logic [IDX_W-1:0] want,
		input logic [IDX_W-1:0] got);
		if (got !== want) begin
			err_cnt++;
			if (err_cnt <= MAX_PRINTS)
				$display("%0t: %s mismatch, expected 0x%03h got 0x%03h",
					$time, name, want, got);
		end
	endtask

	// Result checker and activity count for the watchdog
	always @(posedge clk) begin
		range_result_t want;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_PRINTS)
					$display("%0t: unexpected result, expected none got %0d %0d %0d %0d",
						$time, rsp_ch.first_index, rsp_ch.last_index,
						rsp_ch.match_count, rsp_ch.found);
			end else begin
				want = pending_results.pop_front();
				report_field("first_index", want.first_index, rsp_ch.first_index);
				report_field("last_index", want.last_index, rsp_ch.last_index);
				report_field("match_count", want.match_count, rsp_ch.match_count);
				report_field("found", {{(IDX_W-1){1'b0}}, want.found},
					{{(IDX_W-1){1'b0}}, rsp_ch.found});
			end
		end
	end

	// Result receiver: random stalls, or one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			int unsigned gap;
			if (rsp_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				rsp_hold = 1'b0;
			end else begin
				gap = pick_gap();
				if (gap != 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Watchdog on cycles without any handshake
	initial begin
		idle_cycles = 0;
		@(posedge clk);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("tb_sorted_array_range_search_top failed");
		$finish;
	end

	initial begin
		int unsigned r;
		int          start_cnt;
		err_cnt  = 0;
		sent_cnt = 0;
		no_idle  = 1'b0;
		rsp_hold = 1'b0;
		loaded   = 0;
		arst_n   = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op    <= OP_CLEAR;
		req_ch.value <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_tab[i])
			send_req(dir_tab[i].op, dir_tab[i].value, dir_tab[i].pinned, dir_tab[i].res);
		drain();

		// Back pressure: receiver holds off while queries keep coming
		key_pool.delete();
		send_req(OP_CLEAR, $urandom);
		load_sorted(20, 3);
		no_idle  = 1'b1;
		rsp_hold = 1'b1;
		query_some(12);
		no_idle  = 1'b0;
		drain();

		// Random sequences: mostly sorted loads, some unsorted and noise
		start_cnt = sent_cnt;
		while (sent_cnt - start_cnt < RANDOM_ITEMS) begin
			r       = $urandom_range(0, 99);
			no_idle = ($urandom_range(0, 4) == 0);
			key_pool.delete();
			if (r < 70) begin
				send_req(OP_CLEAR, $urandom);
				r = $urandom_range(0, 99);
				load_sorted((r < 70) ? $urandom_range(0, 12) :
					(r < 95) ? $urandom_range(13, 80) : $urandom_range(81, 300),
					pick_spread());
				query_some($urandom_range(1, 10));
			end else if (r < 85) begin
				send_req(OP_CLEAR, $urandom);
				r = $urandom_range(0, 1);
				repeat ($urandom_range(1, 30)) begin
					logic signed [VAL_W-1:0] v;
					v = (r != 0) ? $signed($urandom_range(0, 8)) - 32'sd4 : $signed($urandom);
					send_req(OP_APPEND, v);
					key_pool.push_back(v);
				end
				query_some($urandom_range(1, 8));
			end else begin
				repeat ($urandom_range(1, 8))
					send_req(OP_W'($urandom_range(0, 3)), $urandom);
			end
			if ($urandom_range(0, 4) == 0)
				drain();
		end
		no_idle = 1'b0;

		// Full store: appends past the end saturate
		key_pool.delete();
		send_req(OP_CLEAR, '0);
		load_sorted(DEPTH + 6, $urandom_range(0, 2));
		query_some(30);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_results.size() == 0)
			$display("tb_sorted_array_range_search_top passed");
		else
			$display("tb_sorted_array_range_search_top failed");
		$finish;
	end

endmodule
